// ===== sv/oows_pkg.sv =====
// ----------------------------------------------------------------------------
// oows_pkg
// Shared types and constants of the online/offline window summer.
// ----------------------------------------------------------------------------
package oows_pkg;

  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned WLEN_W    = 11;
  localparam int unsigned SEEN_W    = 11;
  localparam int unsigned TOTAL_W   = 26;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // A class reports only after more than this many samples.
  localparam int unsigned MIN_SEEN  = 5;

  localparam logic [WLEN_W-1:0]  WLEN_RESET       = WLEN_W'(1000);
  localparam logic [COUNT_W-1:0] MIN_REF_RESET    = COUNT_W'(1);
  localparam logic [CODE_W-1:0]  CODE_ON_L_RESET  = CODE_W'(0);
  localparam logic [CODE_W-1:0]  CODE_ON_R_RESET  = CODE_W'(1);
  localparam logic [CODE_W-1:0]  CODE_OFF_L_RESET = CODE_W'(2);
  localparam logic [CODE_W-1:0]  CODE_OFF_R_RESET = CODE_W'(3);

  typedef enum logic [1:0] {
    FLAG_NONE   = 2'd0,
    FLAG_RIGHT  = 2'd1,
    FLAG_LEFT   = 2'd2,
    FLAG_ONLINE = 2'd3
  } class_flag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH   = 3'd0,
    REG_MIN_REF_COUNTS  = 3'd1,
    REG_CODE_ONLINE_L   = 3'd2,
    REG_CODE_ONLINE_R   = 3'd3,
    REG_CODE_OFFLINE_L  = 3'd4,
    REG_CODE_OFFLINE_R  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] min_reference_counts;
    logic [CODE_W-1:0]  code_online_left;
    logic [CODE_W-1:0]  code_online_right;
    logic [CODE_W-1:0]  code_offline_left;
    logic [CODE_W-1:0]  code_offline_right;
  } class_cfg_t;

endpackage

// ===== sv/oows_if.sv =====
// ----------------------------------------------------------------------------
// oows_sample_if / oows_result_if
// Valid/ready channels for sample records and window reports.
// ----------------------------------------------------------------------------
interface oows_sample_if;
  import oows_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [COUNT_W-1:0]        reference_counts;
  logic [COUNT_W-1:0]        signal_counts;
  logic signed [POS_W-1:0]   current_position;
  logic signed [POS_W-1:0]   online_position;
  logic [COUNT_W-1:0]        dither_width;
  logic [COUNT_W-1:0]        step_left;
  logic [COUNT_W-1:0]        step_right;
  logic [CODE_W-1:0]         action_code;

  modport source (
    output valid, reference_counts, signal_counts, current_position, online_position,
           dither_width, step_left, step_right, action_code,
    input  ready
  );
  modport sink (
    input  valid, reference_counts, signal_counts, current_position, online_position,
           dither_width, step_left, step_right, action_code,
    output ready
  );
endinterface

interface oows_result_if;
  import oows_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         class_flag;
  logic [TOTAL_W-1:0] online_total;
  logic [SEEN_W-1:0]  online_entries;
  logic [TOTAL_W-1:0] left_total;
  logic [SEEN_W-1:0]  left_entries;
  logic [TOTAL_W-1:0] right_total;
  logic [SEEN_W-1:0]  right_entries;

  modport source (
    output valid, class_flag, online_total, online_entries, left_total, left_entries,
           right_total, right_entries,
    input  ready
  );
  modport sink (
    input  valid, class_flag, online_total, online_entries, left_total, left_entries,
           right_total, right_entries,
    output ready
  );
endinterface

// ===== sv/online_offline_window_summer_core.sv =====
// ----------------------------------------------------------------------------
// online_offline_window_summer_core
// Classifies sample records and reports windowed sums per class.
//
//   channel   direction  contents
//   sample    in         one sample record per transaction
//   result    out        class flag and three sums with entry counts
//   cfg_*     in         register writes, index and 16-bit data
//
// One transaction is taken per cycle while the result is not stalled; each
// sample passes the input register, class register and result register.
// The ring update is a read-modify-write against a prefetched
// RAM word, which sets the one-per-cycle rate.
// Each stage advances when the stage behind it is empty or moving, so a
// stalled result blocks input only once every stage is full.
// Reset (rst) and any window_length write empty all windows at once; no
// clearing pass over the rings is needed.
// ----------------------------------------------------------------------------
module online_offline_window_summer_core import oows_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  oows_sample_if.sink          sample,
  oows_result_if.source        result
);

  localparam int unsigned LW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CW = (LW > WLEN_W) ? LW : WLEN_W;

  // Configuration
  logic [WLEN_W-1:0] window_length;
  class_cfg_t        cfg;
  logic              win_clr;
  logic [LW-1:0]     len;
  logic [CW-1:0]     wlen_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length            <= WLEN_RESET;
      cfg.min_reference_counts <= MIN_REF_RESET;
      cfg.code_online_left     <= CODE_ON_L_RESET;
      cfg.code_online_right    <= CODE_ON_R_RESET;
      cfg.code_offline_left    <= CODE_OFF_L_RESET;
      cfg.code_offline_right   <= CODE_OFF_R_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH:  window_length            <= cfg_data[WLEN_W-1:0];
        REG_MIN_REF_COUNTS: cfg.min_reference_counts <= cfg_data[COUNT_W-1:0];
        REG_CODE_ONLINE_L:  cfg.code_online_left     <= cfg_data[CODE_W-1:0];
        REG_CODE_ONLINE_R:  cfg.code_online_right    <= cfg_data[CODE_W-1:0];
        REG_CODE_OFFLINE_L: cfg.code_offline_left    <= cfg_data[CODE_W-1:0];
        REG_CODE_OFFLINE_R: cfg.code_offline_right   <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign win_clr = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

  // Effective window length, clamped to 1..WINDOW_DEPTH.
  always_comb begin
    wlen_x = CW'(window_length);
    if (wlen_x == '0) begin
      len = LW'(1);
    end else if (wlen_x > CW'(WINDOW_DEPTH)) begin
      len = LW'(WINDOW_DEPTH);
    end else begin
      len = LW'(wlen_x);
    end
  end

  // Pipeline control
  logic out_rdy;
  logic s2_rdy;
  logic s1_rdy;
  logic s1_valid;
  logic s2_valid;
  logic res_valid;
  logic advance;

  assign out_rdy      = !res_valid || result.ready;
  assign s2_rdy       = !s2_valid || out_rdy;
  assign s1_rdy       = !s1_valid || s2_rdy;
  assign sample.ready = s1_rdy;
  assign advance      = s2_valid && out_rdy;

  // Stage 1: input register
  logic [COUNT_W-1:0]      s1_ref;
  logic [COUNT_W-1:0]      s1_sig;
  logic signed [POS_W-1:0] s1_cur;
  logic signed [POS_W-1:0] s1_onl;
  logic [COUNT_W-1:0]      s1_dither;
  logic [COUNT_W-1:0]      s1_step_l;
  logic [COUNT_W-1:0]      s1_step_r;
  logic [CODE_W-1:0]       s1_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid <= sample.valid;
    end
    if (s1_rdy && sample.valid) begin
      s1_ref    <= sample.reference_counts;
      s1_sig    <= sample.signal_counts;
      s1_cur    <= sample.current_position;
      s1_onl    <= sample.online_position;
      s1_dither <= sample.dither_width;
      s1_step_l <= sample.step_left;
      s1_step_r <= sample.step_right;
      s1_act    <= sample.action_code;
    end
  end

  // Stage 2: class register
  class_flag_t        s1_flag;
  class_flag_t        s2_flag;
  logic [COUNT_W-1:0] s2_sig;

  oows_classify u_classify (
    .cfg              (cfg),
    .reference_counts (s1_ref),
    .current_position (s1_cur),
    .online_position  (s1_onl),
    .dither_width     (s1_dither),
    .step_left        (s1_step_l),
    .step_right       (s1_step_r),
    .action_code      (s1_act),
    .class_flag       (s1_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid <= s1_valid;
    end
    if (s2_rdy && s1_valid) begin
      s2_flag <= s1_flag;
      s2_sig  <= s1_sig;
    end
  end

  // Class windows
  logic [TOTAL_W-1:0] on_total;
  logic [SEEN_W-1:0]  on_entries;
  logic [TOTAL_W-1:0] lf_total;
  logic [SEEN_W-1:0]  lf_entries;
  logic [TOTAL_W-1:0] rt_total;
  logic [SEEN_W-1:0]  rt_entries;

  oows_window #(.DEPTH (WINDOW_DEPTH)) u_win_online (
    .clk     (clk),
    .rst     (rst),
    .clr     (win_clr),
    .push    (advance && (s2_flag == FLAG_ONLINE)),
    .sig     (s2_sig),
    .len     (len),
    .total   (on_total),
    .entries (on_entries)
  );

  oows_window #(.DEPTH (WINDOW_DEPTH)) u_win_left (
    .clk     (clk),
    .rst     (rst),
    .clr     (win_clr),
    .push    (advance && (s2_flag == FLAG_LEFT)),
    .sig     (s2_sig),
    .len     (len),
    .total   (lf_total),
    .entries (lf_entries)
  );

  oows_window #(.DEPTH (WINDOW_DEPTH)) u_win_right (
    .clk     (clk),
    .rst     (rst),
    .clr     (win_clr),
    .push    (advance && (s2_flag == FLAG_RIGHT)),
    .sig     (s2_sig),
    .len     (len),
    .total   (rt_total),
    .entries (rt_entries)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_rdy) begin
      res_valid <= s2_valid;
    end
    if (advance) begin
      result.class_flag     <= s2_flag;
      result.online_total   <= on_total;
      result.online_entries <= on_entries;
      result.left_total     <= lf_total;
      result.left_entries   <= lf_entries;
      result.right_total    <= rt_total;
      result.right_entries  <= rt_entries;
    end
  end

  assign result.valid = res_valid;

endmodule

// ===== sv/oows_ram.sv =====
// ----------------------------------------------------------------------------
// oows_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module oows_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/oows_classify.sv =====
// ----------------------------------------------------------------------------
// oows_classify
// Decides whether a sample is online, left offline, right offline or none.
// ----------------------------------------------------------------------------
module oows_classify import oows_pkg::*; (
  input  class_cfg_t              cfg,
  input  logic [COUNT_W-1:0]      reference_counts,
  input  logic signed [POS_W-1:0] current_position,
  input  logic signed [POS_W-1:0] online_position,
  input  logic [COUNT_W-1:0]      dither_width,
  input  logic [COUNT_W-1:0]      step_left,
  input  logic [COUNT_W-1:0]      step_right,
  input  logic [CODE_W-1:0]       action_code,
  output class_flag_t             class_flag
);

  // One extra bit keeps the position arithmetic exact.
  logic signed [POS_W:0] cur_x;
  logic signed [POS_W:0] onl_x;
  logic signed [POS_W:0] pos_diff;
  logic [POS_W:0]        pos_diff_abs;
  logic                  online_hit;
  logic                  left_hit;
  logic                  right_hit;

  always_comb begin
    cur_x        = {current_position[POS_W-1], current_position};
    onl_x        = {online_position[POS_W-1], online_position};
    pos_diff     = cur_x - onl_x;
    pos_diff_abs = pos_diff[POS_W] ? (POS_W+1)'(-pos_diff) : pos_diff;

    online_hit = (reference_counts > cfg.min_reference_counts)
              && (pos_diff_abs <= (POS_W+1)'(dither_width))
              && ((action_code == cfg.code_online_left)
               || (action_code == cfg.code_online_right));
    left_hit   = (cur_x == onl_x - $signed({1'b0, (POS_W)'(step_left)}))
              && (action_code == cfg.code_offline_left);
    right_hit  = (cur_x == onl_x + $signed({1'b0, (POS_W)'(step_right)}))
              && (action_code == cfg.code_offline_right);

    if (online_hit) begin
      class_flag = FLAG_ONLINE;
    end else if (left_hit) begin
      class_flag = FLAG_LEFT;
    end else if (right_hit) begin
      class_flag = FLAG_RIGHT;
    end else begin
      class_flag = FLAG_NONE;
    end
  end

endmodule

// ===== sv/oows_window.sv =====
// ----------------------------------------------------------------------------
// oows_window
// Ring buffer with running sum for one class, and its report.
// ----------------------------------------------------------------------------
module oows_window import oows_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic                       push,
  input  logic [COUNT_W-1:0]         sig,
  input  logic [$clog2(DEPTH+1)-1:0] len,
  output logic [TOTAL_W-1:0]         total,
  output logic [SEEN_W-1:0]          entries
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > SEEN_W) ? LW : SEEN_W;

  logic [AW-1:0]      slot;
  logic [AW-1:0]      slot_next;
  logic               wrapped;
  logic               wrapped_next;
  logic [SEEN_W-1:0]  seen;
  logic [SEEN_W-1:0]  seen_next;
  logic [TOTAL_W-1:0] running;
  logic [TOTAL_W-1:0] running_next;
  logic               fwd;
  logic [COUNT_W-1:0] fwd_data;
  logic [COUNT_W-1:0] rdata;
  logic [COUNT_W-1:0] head;
  logic [COUNT_W-1:0] old_val;
  logic               at_end;
  logic [CW-1:0]      seen_x;
  logic [CW-1:0]      len_x;

  oows_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (slot),
    .wdata (sig),
    .raddr (slot_next),
    .rdata (rdata)
  );

  // The RAM read, with forwarding for a one-entry ring, prefetches the entry at the current slot.
  // Until the ring has wrapped once, that entry is not part of the window and counts as zero.
  always_comb begin
    head    = fwd ? fwd_data : rdata;
    old_val = wrapped ? head : '0;
    at_end  = ((LW)'(slot) + LW'(1)) == len;

    slot_next    = slot;
    wrapped_next = wrapped;
    seen_next    = seen;
    running_next = running;
    if (clr) begin
      slot_next    = '0;
      wrapped_next = 1'b0;
      seen_next    = '0;
      running_next = '0;
    end else if (push) begin
      slot_next    = at_end ? '0 : slot + AW'(1);
      wrapped_next = wrapped | at_end;
      seen_next    = (&seen) ? seen : seen + SEEN_W'(1);
      running_next = running - TOTAL_W'(old_val) + TOTAL_W'(sig);
    end

    seen_x = CW'(seen_next);
    len_x  = CW'(len);
    if (seen_next > SEEN_W'(MIN_SEEN)) begin
      total   = running_next;
      entries = (seen_x < len_x) ? seen_next : SEEN_W'(len_x);
    end else begin
      total   = '0;
      entries = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
      seen    <= '0;
      running <= '0;
      fwd     <= 1'b0;
    end else begin
      slot    <= slot_next;
      wrapped <= wrapped_next;
      seen    <= seen_next;
      running <= running_next;
      // A one-entry ring reads the slot it writes in the same cycle.
      fwd     <= push && !clr && (slot_next == slot);
    end
    fwd_data <= sig;
  end

endmodule
